// File: rtl/dcl_pkg.sv
// Shared types and constants of the deadband change logger.
package dcl_pkg;

	localparam int VAL_W = 64;
	localparam int TIME_W = 48;
	localparam int TO_W = 32;
	localparam int DB_W = 64;
	localparam int KIND_W = 3;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 64;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_KIND = 8'd3;

	// trigger modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_CHANGE = 1'b1;

	// size field of data_kind (bits 2:1); bit 0 marks a signed kind
	localparam logic [1:0] SZ_8 = 2'd0;
	localparam logic [1:0] SZ_16 = 2'd1;
	localparam logic [1:0] SZ_32 = 2'd2;
	localparam logic [1:0] SZ_64 = 2'd3;

	localparam logic [KIND_W-1:0] KIND_RESET = 3'd5;

	// decoupling queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [VAL_W-1:0] sample_bits;
		logic [TIME_W-1:0] sample_time;
	} in_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] record_value;
		logic [TIME_W-1:0] record_time;
		logic record_is_gap;
		logic last_of_run;
	} rec_item_t;

	// one classified sample: optional leading record, then the sample itself
	typedef struct packed {
		logic has_first;
		logic first_is_gap;
		logic [VAL_W-1:0] first_value;
		logic [TIME_W-1:0] first_time;
		logic [VAL_W-1:0] sample_value;
		logic [TIME_W-1:0] sample_time;
	} q_entry_t;

endpackage

// File: rtl/deadband_change_logger.sv
// Top level of the deadband change logger: front, queue and back.
// The first record of a sample is registered in the queue and then in the back end's output register.
// Throughput: one request per cycle into a two-entry queue while the queue is not full;
// the back end emits one record per cycle unless the output stalls, a sample with a
// leading record giving two records there, and a suppressed sample never enters the queue.
// Reset: change mode, deadband 0, timeout off, kind s32; logger state cleared.
module deadband_change_logger #(
	parameter int VALUE_BYTES = 8,
	parameter int TIME_BITS = 48
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [dcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dcl_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input dcl_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output dcl_pkg::rec_item_t out_data
);
	import dcl_pkg::*;

	// front to queue
	logic push_valid, push_ready;
	q_entry_t push_entry;
	// queue to back
	logic pop_valid, pop;
	q_entry_t pop_entry;

	// register writes never stall
	assign cfg_ready = 1'b1;

	// Front: decides per request whether it yields zero, one or two records
	// and updates the compare, held and last-time state in the same cycle,
	// so the next request sees it at once.
	dcl_front #(
		.VALUE_BYTES(VALUE_BYTES),
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.push_ready(push_ready),
		.push_valid(push_valid),
		.push_entry(push_entry)
	);

	// Queue: holds classified samples so the input keeps flowing while
	// the output side stalls, until both entries are taken.
	dcl_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid(pop_valid),
		.pop(pop),
		.pop_entry(pop_entry)
	);

	// Back: plays out the gap marker or held sample first, then the sample
	// itself flagged as the last of its run.
	dcl_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(pop_valid),
		.q_entry(pop_entry),
		.q_pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

// File: rtl/dcl_front.sv
// Front end: configuration registers, sample classification and logger state.
module dcl_front #(
	parameter int VALUE_BYTES = 8,
	parameter int TIME_BITS = 48
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [dcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dcl_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input dcl_pkg::in_item_t in_data,
	input logic push_ready,
	output logic push_valid,
	output dcl_pkg::q_entry_t push_entry
);
	import dcl_pkg::*;

	localparam int CAP_W = 8 * VALUE_BYTES;
	localparam logic [VAL_W-1:0] CAP_MASK = {VAL_W{1'b1}} >> (VAL_W - CAP_W);
	localparam int TB = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
	localparam logic [TIME_W-1:0] TIME_MASK = {TIME_W{1'b1}} >> (TIME_W - TB);

	logic mode_q;
	logic [DB_W-1:0] deadband_q;
	logic [TO_W-1:0] timeout_q;
	logic [KIND_W-1:0] kind_q;
	logic [VAL_W-1:0] compare_q;
	logic [VAL_W-1:0] held_q;
	logic held_written_q;
	logic [TIME_W-1:0] last_time_q;

	logic [VAL_W-1:0] kind_mask, val_mask, top_mask, sample_r;
	logic [VAL_W-1:0] key_c, key_s, abs_diff, diff_ba;
	logic [VAL_W:0] diff_ab;
	logic changed, timed_out, is_change, emit, accept;
	logic [TIME_W-1:0] now, timeout_ext, gap_time;
	logic [TIME_W:0] elapsed, gap_diff;

	// maps a value to an unsigned key of the same order at the current kind
	function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] x,
			input logic [VAL_W-1:0] mask, input logic [VAL_W-1:0] top, input logic sgn);
		logic [VAL_W-1:0] v;
		logic [VAL_W-1:0] ext;
		v = x & mask;
		ext = (sgn && (|(v & top))) ? (v | ~mask) : v;
		order_key = sgn ? {~ext[VAL_W-1], ext[VAL_W-2:0]} : ext;
	endfunction

	always_comb begin
		case (kind_q[2:1])
			SZ_8: kind_mask = {{(VAL_W-8){1'b0}}, {8{1'b1}}};
			SZ_16: kind_mask = {{(VAL_W-16){1'b0}}, {16{1'b1}}};
			SZ_32: kind_mask = {{(VAL_W-32){1'b0}}, {32{1'b1}}};
			SZ_64: kind_mask = {VAL_W{1'b1}};
			default: kind_mask = {VAL_W{1'b1}};
		endcase
		val_mask = kind_mask & CAP_MASK;
		top_mask = val_mask ^ (val_mask >> 1);
		sample_r = in_data.sample_bits & val_mask;

		key_c = order_key(compare_q, val_mask, top_mask, kind_q[0]);
		key_s = order_key(in_data.sample_bits, val_mask, top_mask, kind_q[0]);
		diff_ab = {1'b0, key_c} - {1'b0, key_s};
		diff_ba = key_s - key_c;
		abs_diff = diff_ab[VAL_W] ? diff_ba : diff_ab[VAL_W-1:0];
		changed = abs_diff >= deadband_q;

		// time going backwards counts as no elapsed time
		now = in_data.sample_time & TIME_MASK;
		timeout_ext = {{(TIME_W-TO_W){1'b0}}, timeout_q};
		elapsed = {1'b0, now} - {1'b0, last_time_q};
		timed_out = (timeout_q != '0) && !elapsed[TIME_W]
			&& (elapsed[TIME_W-1:0] > timeout_ext);
		gap_diff = {1'b0, now} - {1'b0, timeout_ext};
		gap_time = gap_diff[TIME_W] ? '0 : gap_diff[TIME_W-1:0];

		is_change = (mode_q == MODE_CHANGE);
		emit = timed_out || !is_change || changed;
		in_ready = push_ready;
		accept = in_valid && in_ready;
		push_valid = accept && emit;

		push_entry.has_first = timed_out || (is_change && changed && !held_written_q);
		push_entry.first_is_gap = timed_out;
		push_entry.first_value = timed_out ? '0 : (held_q & val_mask);
		push_entry.first_time = timed_out ? gap_time : last_time_q;
		push_entry.sample_value = sample_r;
		push_entry.sample_time = now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CHANGE;
			deadband_q <= '0;
			timeout_q <= '0;
			kind_q <= KIND_RESET;
			compare_q <= '0;
			held_q <= '0;
			held_written_q <= 1'b1;
			last_time_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TRIGGER_MODE: mode_q <= cfg_data[0];
					CFG_DEADBAND: deadband_q <= cfg_data[DB_W-1:0];
					CFG_TIMEOUT: timeout_q <= cfg_data[TO_W-1:0];
					CFG_DATA_KIND: kind_q <= cfg_data[KIND_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				last_time_q <= now;
				if (timed_out) begin
					if (is_change) begin
						held_q <= sample_r;
						compare_q <= sample_r;
						held_written_q <= 1'b1;
					end
				end else if (is_change) begin
					if (changed) begin
						held_written_q <= 1'b1;
						compare_q <= sample_r;
					end else begin
						held_q <= sample_r;
						held_written_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

// File: rtl/dcl_queue.sv
// Two-entry queue of classified samples between front and back.
module dcl_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input dcl_pkg::q_entry_t push_entry,
	output logic pop_valid,
	input logic pop,
	output dcl_pkg::q_entry_t pop_entry
);
	import dcl_pkg::*;

	q_entry_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");
	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> rd_ptr_q == wr_ptr_q)
		else $error("empty queue with pointers apart");
`endif

endmodule

// File: rtl/dcl_back.sv
// Back end: expands queued samples into records behind an output register.
module dcl_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input dcl_pkg::q_entry_t q_entry,
	output logic q_pop,
	output logic out_valid,
	input logic out_ready,
	output dcl_pkg::rec_item_t out_data
);
	import dcl_pkg::*;

	logic out_valid_q;
	rec_item_t out_data_q;
	logic phase_q;
	logic load, first_now;
	rec_item_t rec;

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		load = !out_valid_q || out_ready;
		first_now = q_entry.has_first && !phase_q;
		q_pop = load && q_valid && !first_now;
		if (first_now) begin
			rec.record_value = q_entry.first_value;
			rec.record_time = q_entry.first_time;
			rec.record_is_gap = q_entry.first_is_gap;
			rec.last_of_run = 1'b0;
		end else begin
			rec.record_value = q_entry.sample_value;
			rec.record_time = q_entry.sample_time;
			rec.record_is_gap = 1'b0;
			rec.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			out_data_q <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= q_valid;
			if (q_valid) begin
				phase_q <= first_now;
			end
		end
	end

`ifndef SYNTH
	a_gap_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.record_is_gap |-> !out_data_q.last_of_run)
		else $error("gap marker closed a run");
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ready && !out_data_q.last_of_run |=> out_valid_q)
		else $error("run ended without its sample record");
	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> q_valid && q_entry.has_first)
		else $error("second record pending with no queued sample");
`endif

endmodule

// File: tb/dcl_log_checker.sv
// Record checker for the deadband change logger: tracks registers, predicts records, compares.
module dcl_log_checker #(
	parameter int VALUE_BYTES = 8,
	parameter int TIME_BITS = 48
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [dcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dcl_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	input logic in_ready,
	input dcl_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input dcl_pkg::rec_item_t out_data,
	output int fail_count,
	output int pending,
	output int samples_seen,
	output int records_seen,
	output int gaps_seen,
	output int held_back
);
	timeunit 1ns;
	timeprecision 1ps;
	import dcl_pkg::*;

	localparam logic [TIME_W-1:0] STAMP_MASK =
		(TIME_BITS >= TIME_W) ? {TIME_W{1'b1}} : TIME_W'((64'd1 << TIME_BITS) - 1);

	// register copies
	logic mode_q;
	logic [DB_W-1:0] db_q;
	logic [TO_W-1:0] tmo_q;
	logic [KIND_W-1:0] kind_q;

	// logger state
	logic [VAL_W-1:0] ref_val;
	logic [VAL_W-1:0] held_val;
	logic held_done;
	logic [TIME_W-1:0] last_t;

	rec_item_t expected_q[$];
	rec_item_t want;

	function automatic int kind_bits(logic [KIND_W-1:0] k);
		int w;
		w = 8 << k[2:1];
		return (w < 8 * VALUE_BYTES) ? w : 8 * VALUE_BYTES;
	endfunction

	function automatic logic [VAL_W-1:0] width_mask(logic [KIND_W-1:0] k);
		return {VAL_W{1'b1}} >> (VAL_W - kind_bits(k));
	endfunction

	// unsigned key with the same order as the value at kind k
	function automatic logic [VAL_W-1:0] sort_key(logic [VAL_W-1:0] v, logic [KIND_W-1:0] k);
		logic [VAL_W-1:0] key;
		logic [VAL_W-1:0] sgn;
		key = v & width_mask(k);
		if (k[0]) begin
			sgn = 64'd1 << (kind_bits(k) - 1);
			key = (key ^ sgn) - sgn;
			key[VAL_W-1] = ~key[VAL_W-1];
		end
		return key;
	endfunction

	function automatic logic past_deadband(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
		logic [VAL_W-1:0] ka;
		logic [VAL_W-1:0] kb;
		ka = sort_key(a, kind_q);
		kb = sort_key(b, kind_q);
		return ((ka > kb) ? ka - kb : kb - ka) >= db_q;
	endfunction

	function automatic rec_item_t make_rec(logic [VAL_W-1:0] v, logic [TIME_W-1:0] t, logic gap);
		rec_item_t r;
		r.record_value = v;
		r.record_time = t;
		r.record_is_gap = gap;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	task automatic log_sample(input in_item_t it);
		rec_item_t recs[$];
		logic [VAL_W-1:0] val;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] elapsed;
		val = it.sample_bits & width_mask(kind_q);
		now = it.sample_time & STAMP_MASK;
		// time running backwards counts as no time at all
		elapsed = (now >= last_t) ? now - last_t : '0;
		if (tmo_q != 0 && elapsed > tmo_q) begin
			recs.push_back(make_rec('0, (now >= tmo_q) ? now - tmo_q : '0, 1'b1));
			recs.push_back(make_rec(val, now, 1'b0));
			if (mode_q == MODE_CHANGE) begin
				held_val = val;
				ref_val = val;
				held_done = 1'b1;
			end
		end else if (mode_q == MODE_WRITE) begin
			recs.push_back(make_rec(val, now, 1'b0));
		end else if (past_deadband(ref_val, val)) begin
			if (!held_done) begin
				recs.push_back(make_rec(held_val & width_mask(kind_q), last_t, 1'b0));
				held_done = 1'b1;
			end
			recs.push_back(make_rec(val, now, 1'b0));
			ref_val = val;
		end else begin
			held_val = val;
			held_done = 1'b0;
			held_back++;
		end
		last_t = now;
		if (recs.size() > 0)
			recs[recs.size() - 1].last_of_run = 1'b1;
		foreach (recs[i]) begin
			if (recs[i].record_is_gap)
				gaps_seen++;
			expected_q.push_back(recs[i]);
		end
	endtask

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (got_v !== exp_v) begin
			fail_count++;
			$display("%0t: record %0d %s mismatch, expected %h, got %h",
				$time, records_seen, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = MODE_CHANGE;
			db_q = '0;
			tmo_q = '0;
			kind_q = KIND_RESET;
			ref_val = '0;
			held_val = '0;
			held_done = 1'b1;
			last_t = '0;
			expected_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TRIGGER_MODE: mode_q = cfg_data[0];
					CFG_DEADBAND: db_q = cfg_data[DB_W-1:0];
					CFG_TIMEOUT: tmo_q = cfg_data[TO_W-1:0];
					CFG_DATA_KIND: kind_q = cfg_data[KIND_W-1:0];
					default: ;
				endcase
			end
			// predict first: a record can never overtake its own sample
			if (in_valid && in_ready) begin
				samples_seen++;
				log_sample(in_data);
			end
			if (out_valid && out_ready) begin
				records_seen++;
				if (expected_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected record, expected none, got %h",
						$time, out_data);
				end else begin
					want = expected_q.pop_front();
					check_field("record_value", want.record_value, out_data.record_value);
					check_field("record_time", want.record_time, out_data.record_time);
					check_field("record_is_gap", want.record_is_gap, out_data.record_is_gap);
					check_field("last_of_run", want.last_of_run, out_data.last_of_run);
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

// File: tb/deadband_change_logger_test.sv
// Top of the deadband change logger testbench: clock, reset, stimulus and verdict.
module deadband_change_logger_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dcl_pkg::*;

	localparam int N_VALUE_BYTES = 8;
	localparam int N_TIME_BITS = 48;

	// data_kind codes: size field in bits 2:1, signed flag in bit 0
	localparam logic [KIND_W-1:0] KIND_U8 = {SZ_8, 1'b0};
	localparam logic [KIND_W-1:0] KIND_S8 = {SZ_8, 1'b1};
	localparam logic [KIND_W-1:0] KIND_U16 = {SZ_16, 1'b0};
	localparam logic [KIND_W-1:0] KIND_U64 = {SZ_64, 1'b0};
	localparam logic [KIND_W-1:0] KIND_S64 = {SZ_64, 1'b1};

	localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};
	localparam logic [VAL_W-1:0] MIN_S64 = 64'h8000_0000_0000_0000;
	localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	rec_item_t out_data;

	int fail_count;
	int pending;
	int samples_seen;
	int records_seen;
	int gaps_seen;
	int held_back;

	// what the stimulus believes the registers hold; steers value and time choices
	logic cur_mode;
	logic [DB_W-1:0] cur_db;
	logic [TO_W-1:0] cur_tmo;
	logic [KIND_W-1:0] cur_kind;

	logic [VAL_W-1:0] walk;    // random walk of the process value
	logic [TIME_W-1:0] stamp;  // running sample time
	logic tx_steady;           // no sender gaps in this phase
	int rx_hold;
	int rx_roll;
	int settings;
	int reg_writes;
	int target;

	deadband_change_logger #(
		.VALUE_BYTES(N_VALUE_BYTES),
		.TIME_BITS(N_TIME_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	dcl_log_checker #(
		.VALUE_BYTES(N_VALUE_BYTES),
		.TIME_BITS(N_TIME_BITS)
	) log_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.fail_count(fail_count),
		.pending(pending),
		.samples_seen(samples_seen),
		.records_seen(records_seen),
		.gaps_seen(gaps_seen),
		.held_back(held_back)
	);

	always #6 clk = ~clk;

	// Receiver pacing, chosen anew whenever the hold count runs out: mostly short
	// stretches of ready or stall, now and then a long stall, and now and then a long
	// stretch of steady ready so that back-to-back two-record samples are seen too.
	always @(negedge clk) begin
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 55) begin
				out_ready <= 1'b1;
				rx_hold <= $urandom_range(0, 3);
			end else if (rx_roll < 90) begin
				out_ready <= 1'b0;
				rx_hold <= $urandom_range(0, 2);
			end else if (rx_roll < 95) begin
				out_ready <= 1'b0;
				rx_hold <= $urandom_range(8, 40);
			end else begin
				out_ready <= 1'b1;
				rx_hold <= $urandom_range(30, 150);
			end
		end
	end

	// Sender gap before the next request: mostly none or short, rarely long.
	function automatic int tx_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (tx_steady || roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 8);
		return $urandom_range(10, 30);
	endfunction

	// One sample request. Called right after the previous acceptance, so the
	// first falling edge here is the one that either drops valid or replaces
	// the payload; valid is never lowered and raised in the same step.
	task automatic push_sample(input logic [VAL_W-1:0] bits, input logic [TIME_W-1:0] t);
		int gap;
		gap = tx_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= {bits, t};
		do @(posedge clk); while (!in_ready);
	endtask

	// Let the block run dry: every predicted record out, then a short pause.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	// Write all four registers; unused data bits carry junk, which the block
	// must drop. Sometimes an unmapped index is written as well.
	task automatic program_regs(input logic mode, input logic [DB_W-1:0] db,
			input logic [TO_W-1:0] tmo, input logic [KIND_W-1:0] kind);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		cfg_write(CFG_TRIGGER_MODE, {junk[63:1], mode});
		cfg_write(CFG_DEADBAND, db);
		cfg_write(CFG_TIMEOUT, {junk[31:0], tmo});
		cfg_write(CFG_DATA_KIND, {junk[63:KIND_W], kind});
		if ($urandom_range(0, 3) == 0)
			cfg_write(CFG_IDX_W'($urandom_range(4, 255)), {$urandom, $urandom});
		cur_mode = mode;
		cur_db = db;
		cur_tmo = tmo;
		cur_kind = kind;
		settings++;
	endtask

	function automatic logic [DB_W-1:0] pick_deadband(input logic [KIND_W-1:0] kind);
		logic [VAL_W-1:0] span;
		span = ALL_ONES >> (64 - (8 << kind[2:1]));
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ALL_ONES;
			2: return DB_W'(1);
			3: return DB_W'($urandom_range(2, 64));
			default: return {$urandom, $urandom} & (span >> $urandom_range(1, 6));
		endcase
	endfunction

	function automatic logic [TO_W-1:0] pick_timeout();
		case ($urandom_range(0, 5))
			0, 1: return '0;
			2: return 1;
			3: return {TO_W{1'b1}};
			4: return $urandom;
			default: return $urandom_range(2, 400);
		endcase
	endfunction

	// Next value: a walk whose steps sit around the deadband, landing on it
	// exactly, just under and just over; sometimes a jump anywhere. Bits above
	// the kind's width are junk.
	function automatic logic [VAL_W-1:0] next_bits();
		logic [VAL_W-1:0] keep;
		logic [VAL_W-1:0] span;
		logic [VAL_W-1:0] step;
		keep = ALL_ONES >> (64 - (8 << cur_kind[2:1]));
		span = (cur_db > keep) ? keep : cur_db;
		case ($urandom_range(0, 9))
			0: step = span;
			1: step = span - 1;
			2: step = span + 1;
			3: step = '0;
			9: step = {$urandom, $urandom};
			default: begin
				if (span == 0)
					step = VAL_W'($urandom_range(0, 20));
				else if (span < 64'h4000_0000_0000_0000)
					step = {$urandom, $urandom} % (2 * span + 1);
				else
					step = {$urandom, $urandom};
			end
		endcase
		walk = $urandom_range(0, 1) ? walk + step : walk - step;
		return (walk & keep) | ({$urandom, $urandom} & ~keep);
	endfunction

	// Next time: mostly forward within the timeout, sometimes exactly on it or
	// one past it, sometimes backwards or a huge jump that may wrap.
	function automatic logic [TIME_W-1:0] next_stamp();
		logic [TIME_W-1:0] inc;
		case ($urandom_range(0, 19))
			0: inc = '0;
			1: inc = TIME_W'(cur_tmo);
			2: inc = TIME_W'(cur_tmo) + 1;
			3: inc = -TIME_W'($urandom_range(1, 5000));
			4: inc = TIME_W'({$urandom, $urandom});
			default: begin
				if (cur_tmo != 0 && cur_tmo < 1_000_000)
					inc = TIME_W'($urandom_range(0, cur_tmo));
				else
					inc = TIME_W'($urandom_range(0, 2000));
			end
		endcase
		stamp = stamp + inc;
		return stamp;
	endfunction

	// Run limit, far above the slowest legal run.
	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		tx_steady = 1'b0;
		settings = 1;
		reg_writes = 0;
		walk = '0;
		stamp = '0;
		cur_mode = MODE_CHANGE;
		cur_db = '0;
		cur_tmo = '0;
		cur_kind = KIND_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: change mode, deadband 0 (every sample counts), s32,
		// no timeout. Field extremes, junk upper bits, time at the top of its
		// range and then running backwards.
		push_sample('0, '0);
		push_sample(ALL_ONES, 5);
		push_sample(64'h0000_0000_8000_0000, 5);
		push_sample(64'hFFFF_FFFF_7FFF_FFFF, 6);
		push_sample(64'h1234, TIME_TOP);
		push_sample(64'h55, 10);
		drain();

		// s8, deadband 100, timeout 50: timeout gap, held-back samples that
		// are flushed ahead of a change, a difference exactly on the deadband,
		// a gap that discards a held sample, silence exactly at the timeout.
		program_regs(MODE_CHANGE, 100, 50, KIND_S8);
		push_sample(64'h00, 100);
		push_sample(64'h10, 110);
		push_sample(64'h20, 120);
		push_sample(64'h80, 130);
		push_sample(64'hE4, 140);
		push_sample(64'h7F, 150);
		push_sample(64'h20, 160);
		push_sample(64'h30, 211);
		push_sample(64'h31, 261);
		drain();

		// u16 with stored state from the s8 phase read at the new kind.
		program_regs(MODE_CHANGE, 64'h8000, 0, KIND_U16);
		push_sample(64'hFFFF_0000_0000_FFFF, 270);
		push_sample(64'h7FFF, 300);
		push_sample(64'h0, 301);
		drain();

		// Write mode, widest timeout, u64: gap one tick past it, none on it.
		program_regs(MODE_WRITE, ALL_ONES, {TO_W{1'b1}}, KIND_U64);
		push_sample('0, '0);
		push_sample(ALL_ONES, 48'h1_0000_0000);
		push_sample(MIN_S64, 48'h1_FFFF_FFFF);
		drain();

		// Huge deadband hit exactly, after a held sample from the u16 phase.
		program_regs(MODE_CHANGE, 64'hFFFF_FFFF_FFFF_8000, 0, KIND_U64);
		push_sample(ALL_ONES, 30);
		drain();

		// Widest deadband with s64 extremes: nothing gets through.
		program_regs(MODE_CHANGE, ALL_ONES, 0, KIND_S64);
		push_sample(MIN_S64, 40);
		push_sample(64'h7FFF_FFFF_FFFF_FFFF, 50);

		// Random phases: every kind in turn first, then random settings.
		target = samples_seen + 1600;
		for (int phase = 0; samples_seen < target; phase++) begin
			logic [KIND_W-1:0] kind;
			logic mode;
			kind = (phase < 8) ? KIND_W'(phase) : KIND_W'($urandom_range(0, 7));
			mode = ($urandom_range(0, 3) != 0) ? MODE_CHANGE : MODE_WRITE;
			drain();
			program_regs(mode, pick_deadband(kind), pick_timeout(), kind);
			tx_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0)
				stamp = TIME_TOP - $urandom_range(0, 100000);
			repeat ($urandom_range(40, 120))
				push_sample(next_bits(), next_stamp());
		end
		drain();

		$display("covered %0d samples under %0d register settings, %0d register writes",
			samples_seen, settings, reg_writes);
		$display("checked %0d records, %0d gap markers, %0d samples held back",
			records_seen, gaps_seen, held_back);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
